FILE: hdl/tim_pkg.sv
// Shared package for the tolerant interval match histogram.
// Table geometry, field widths, bin limits, request codes, state enum, structs and helpers.
// No dependencies.
`default_nettype none

package tim_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int POS_W    = 32;
   localparam int LEN_W    = 16;
   localparam int WINDOW_W = 16;
   localparam int BIN_W    = 32;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(25);

   // length bin limits (inclusive)
   localparam logic [LEN_W-1:0] SHORT_LO = LEN_W'(1);
   localparam logic [LEN_W-1:0] SHORT_HI = LEN_W'(99);
   localparam logic [LEN_W-1:0] MID_LO   = LEN_W'(100);
   localparam logic [LEN_W-1:0] MID_HI   = LEN_W'(199);
   localparam logic [LEN_W-1:0] LONG_LO  = LEN_W'(200);
   localparam logic [LEN_W-1:0] LONG_HI  = LEN_W'(300);

   localparam logic [BIN_W-1:0] BIN_MAX = '1;

   // request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [LEN_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic             matched;
      logic [POS_W-1:0] ref_start;
      logic [POS_W-1:0] ref_end;
      logic [LEN_W-1:0] ref_length;
      logic [BIN_W-1:0] short_bin;
      logic [BIN_W-1:0] mid_bin;
      logic [BIN_W-1:0] long_bin;
      logic             overflow;
      logic             last;
   } result_type;

   // distance between two coordinates within the window, no wrap
   function automatic logic dist_ok(input logic [POS_W-1:0] a,
                                    input logic [POS_W-1:0] b,
                                    input logic [WINDOW_W-1:0] win);
      logic [POS_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return d <= POS_W'(win);
   endfunction

   // saturating increment
   function automatic logic [BIN_W-1:0] sat_inc(input logic [BIN_W-1:0] v);
      return (v == BIN_MAX) ? v : v + BIN_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tim_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on tim_pkg for field widths.
`default_nettype none

interface tim_req_if import tim_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [POS_W-1:0] start_pos;
   logic [POS_W-1:0] end_pos;
   logic [LEN_W-1:0] event_length;

   modport source (output valid, output req_type, output start_pos, output end_pos,
                   output event_length, input ready);
   modport sink   (input valid, input req_type, input start_pos, input end_pos,
                   input event_length, output ready);
endinterface

interface tim_rsp_if import tim_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             matched;
   logic [POS_W-1:0] ref_start;
   logic [POS_W-1:0] ref_end;
   logic [LEN_W-1:0] ref_length;
   logic [BIN_W-1:0] short_bin_count;
   logic [BIN_W-1:0] mid_bin_count;
   logic [BIN_W-1:0] long_bin_count;
   logic             table_overflow;
   logic             last;

   modport source (output valid, output matched, output ref_start, output ref_end,
                   output ref_length, output short_bin_count, output mid_bin_count,
                   output long_bin_count, output table_overflow, output last,
                   input ready);
   modport sink   (input valid, input matched, input ref_start, input ref_end,
                   input ref_length, input short_bin_count, input mid_bin_count,
                   input long_bin_count, input table_overflow, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/tolerant_interval_match_histogram.sv
// Tolerant interval match histogram: ring of table cells, head compare, bin counters.
// A load word is taken while idle. A query word is accepted, then the ring makes
// one full turn of TABLE_DEPTH shifts (one entry compared at the head cell per cycle while
// the response side does not stall) and then closes out in the done state. Results trail their
// match by one held slot. Reset clears the entry count, bin counters, overflow flag and
// sets the window to 25; table cells are not cleared and are only read below the entry count.
`default_nettype none

module tolerant_interval_match_histogram import tim_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   tim_req_if.sink                  req,
   tim_rsp_if.source                rsp,
   input  wire logic                csr_write_en,
   input  wire logic [WINDOW_W-1:0] csr_write_data
);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        step_ff;
   logic [CNT_W-1:0]        entry_count_ff;
   logic                    overflow_ff;
   logic [WINDOW_W-1:0]     window_ff;
   entry_type               query_ff;
   logic [BIN_W-1:0]        short_ff, mid_ff, long_ff;
   logic [BIN_W-1:0]        short_in, mid_in, long_in;
   logic                    hold_valid_ff;
   result_type              hold_ff;
   logic                    rsp_valid_ff;
   result_type              rsp_ff;

   entry_type               cell_q [TABLE_DEPTH];
   cell_ctl_type            cell_ctl [TABLE_DEPTH];
   entry_type               load_data;
   entry_type               head;

   logic load_fire, query_fire, table_full;
   logic in_range, hit, out_free, advance, last_step, finish;
   logic is_short, is_mid, is_long;
   result_type new_hold, final_rsp;

   assign load_fire  = req.valid && req.ready && (req.req_type == REQ_LOAD);
   assign query_fire = req.valid && req.ready && (req.req_type == REQ_QUERY);
   assign table_full = (entry_count_ff == CNT_W'(TABLE_DEPTH));

   assign load_data.start_pos = req.start_pos;
   assign load_data.end_pos   = req.end_pos;
   assign load_data.length    = req.event_length;

   // ring of cells; cell 0 is the head seen by the comparator
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].load  = load_fire && !table_full &&
                                 (entry_count_ff[IDX_W-1:0] == IDX_W'(i));
      assign cell_ctl[i].shift = advance;

      tim_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .load_data  (load_data),
         .shift_data (cell_q[(i + 1) % TABLE_DEPTH]),
         .entry      (cell_q[i])
      );
   end

   assign head = cell_q[0];

   // compare the head entry against the query
   assign in_range  = (step_ff < entry_count_ff);
   assign hit       = (state_ff == ST_SCAN) && in_range &&
                      (head.length == query_ff.length) &&
                      (dist_ok(head.start_pos, query_ff.start_pos, window_ff) ||
                       dist_ok(head.end_pos, query_ff.end_pos, window_ff));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = (state_ff == ST_SCAN) && (!hit || !hold_valid_ff || out_free);
   assign last_step = (step_ff == CNT_W'(TABLE_DEPTH - 1));
   assign finish    = (state_ff == ST_DONE) && out_free;

   // pick the length bin of a matching entry
   assign is_short = (head.length >= SHORT_LO) && (head.length <= SHORT_HI);
   assign is_mid   = (head.length >= MID_LO) && (head.length <= MID_HI);
   assign is_long  = (head.length >= LONG_LO) && (head.length <= LONG_HI);

   always_comb begin
      short_in = short_ff;
      mid_in   = mid_ff;
      long_in  = long_ff;
      if (hit && advance) begin
         if (is_short) begin
            short_in = sat_inc(short_ff);
         end
         if (is_mid) begin
            mid_in = sat_inc(mid_ff);
         end
         if (is_long) begin
            long_in = sat_inc(long_ff);
         end
      end
   end

   // result for the match just found, held until the next one or the end
   always_comb begin
      new_hold.matched    = 1'b1;
      new_hold.ref_start  = head.start_pos;
      new_hold.ref_end    = head.end_pos;
      new_hold.ref_length = head.length;
      new_hold.short_bin  = short_in;
      new_hold.mid_bin    = mid_in;
      new_hold.long_bin   = long_in;
      new_hold.overflow   = overflow_ff;
      new_hold.last       = 1'b0;
   end

   // closing result: the held match marked last, or a no-match word
   always_comb begin
      if (hold_valid_ff) begin
         final_rsp      = hold_ff;
         final_rsp.last = 1'b1;
      end else begin
         final_rsp.matched    = 1'b0;
         final_rsp.ref_start  = '0;
         final_rsp.ref_end    = '0;
         final_rsp.ref_length = '0;
         final_rsp.short_bin  = short_ff;
         final_rsp.mid_bin    = mid_ff;
         final_rsp.long_bin   = long_ff;
         final_rsp.overflow   = overflow_ff;
         final_rsp.last       = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance && last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         entry_count_ff <= '0;
         overflow_ff    <= 1'b0;
         window_ff      <= WINDOW_RESET;
         short_ff       <= '0;
         mid_ff         <= '0;
         long_ff        <= '0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         short_ff <= short_in;
         mid_ff   <= mid_in;
         long_ff  <= long_in;

         if (csr_write_en) begin
            window_ff <= csr_write_data;
         end

         // count loads, flag drops on a full table
         if (load_fire) begin
            if (table_full) begin
               overflow_ff <= 1'b1;
            end else begin
               entry_count_ff <= entry_count_ff + CNT_W'(1);
            end
         end

         // advance the scan position with the ring
         if (query_fire) begin
            step_ff <= '0;
         end else if (advance) begin
            step_ff <= last_step ? '0 : step_ff + CNT_W'(1);
         end

         if (hit && advance) begin
            hold_valid_ff <= 1'b1;
         end else if (finish) begin
            hold_valid_ff <= 1'b0;
         end

         if ((hit && advance && hold_valid_ff) || finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (query_fire) begin
         query_ff <= load_data;
      end
      if (hit && advance) begin
         hold_ff <= new_hold;
      end
      if (hit && advance && hold_valid_ff) begin
         rsp_ff <= hold_ff;
      end else if (finish) begin
         rsp_ff <= final_rsp;
      end
   end

   // drive the response word
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.matched         = rsp_ff.matched;
   assign rsp.ref_start       = rsp_ff.ref_start;
   assign rsp.ref_end         = rsp_ff.ref_end;
   assign rsp.ref_length      = rsp_ff.ref_length;
   assign rsp.short_bin_count = rsp_ff.short_bin;
   assign rsp.mid_bin_count   = rsp_ff.mid_bin;
   assign rsp.long_bin_count  = rsp_ff.long_bin;
   assign rsp.table_overflow  = rsp_ff.overflow;
   assign rsp.last            = rsp_ff.last;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_hold_in_query: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (state_ff != ST_IDLE))
      else $error("held match outside a query");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == '0))
      else $error("scan position not rewound at idle");

   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (state_in == ST_DONE)) |-> last_step)
      else $error("scan ended before a full ring turn");

endmodule

`default_nettype wire

FILE: hdl/tim_cell.sv
// One table cell of the reference ring: holds one interval entry.
// Loads a new entry or takes its neighbor's entry on a ring shift. Depends on tim_pkg.
`default_nettype none

module tim_cell import tim_pkg::*; (
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    load_data,
   input  wire entry_type    shift_data,
   output entry_type         entry
);

   entry_type entry_ff;

   // load from the request, or take the neighbor's entry on a shift
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= load_data;
      end else if (ctl.shift) begin
         entry_ff <= shift_data;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
